// ===== hw/rtl/sna_pkg.sv =====
package sna_pkg;

	// Field widths
	localparam int unsigned STEP_W  = 10;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned ACT_W   = 16;
	localparam int unsigned SLOPE_W = 15;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SUM_W   = 24;

	// Store and table geometry. TABLE_ENTRIES must be a power of two.
	localparam int unsigned SERIES_DEPTH_DEF = 1024;
	localparam int unsigned TABLE_ENTRIES    = 256;
	localparam int unsigned GRID_STEP        = 65536 / TABLE_ENTRIES;
	localparam int unsigned STEP_SH          = $clog2(GRID_STEP);
	localparam int unsigned TAB_IDX_W        = $clog2(TABLE_ENTRIES);

	// Queue depths
	localparam int unsigned JOB_Q_DEPTH = 2;
	localparam int unsigned RES_Q_DEPTH = 2;

	localparam logic [ACT_W-1:0]   ACT_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// exp(-1/4096) in Q0.64
	localparam logic [63:0] EXP_P0 = 64'hFFF0007FFD556000;

	typedef struct packed {
		logic [STEP_W-1:0]         step_index;
		logic signed [VALUE_W-1:0] incoming_value;
	} in_item_t;

	typedef struct packed {
		logic [STEP_W-1:0]  out_step;
		logic [ACT_W-1:0]   activation;
		logic [SLOPE_W-1:0] slope;
		logic               overrun;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]      count;
		logic signed [SUM_W-1:0] sum;
	} entry_t;

	// Status from the back end toward the front end
	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic logic [63:0] mul_high(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64];
	endfunction

	// Restoring long division, used only to build constant table entries
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r    = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sigmoid sample at grid point k: x_k = k*GRID_STEP - 8.0 (Q12)
	function automatic logic [ACT_W-1:0] sig_sample(input int unsigned k);
		logic [63:0]        pw [16];
		logic [63:0]        e;
		logic [63:0]        e32;
		logic [63:0]        d;
		logic [63:0]        s;
		logic signed [31:0] x;
		logic [15:0]        t;
		pw[0] = EXP_P0;
		for (int j = 1; j < 16; j++) begin
			pw[j] = mul_high(pw[j-1], pw[j-1]);
		end
		x = $signed(32'(k * GRID_STEP)) - 32'sd32768;
		t = (x < 0) ? 16'(-x) : 16'(x);
		e = '1;
		for (int j = 0; j < 16; j++) begin
			if (t[j]) begin
				e = mul_high(e, pw[j]);
			end
		end
		e32 = e >> 32;
		d   = 64'h1_0000_0000 + e32;
		if (x >= 0) begin
			s = long_div((64'd1 << 48) + (d >> 1), d);
		end else begin
			s = long_div((e32 << 16) + (d >> 1), d);
		end
		if (s > 64'd65535) begin
			s = 64'd65535;
		end
		return s[ACT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/sigmoid_neuron_accumulate_top.sv =====
// Channel   | Handshake                  | Word
// ----------+----------------------------+------------------------------------------
// input     | push / full                | item: step_index, incoming_value
// result    | pop / empty                | result: out_step, activation, slope, overrun
// config    | cfg_valid / cfg_ready      | cfg_data: fan_in_count
//
// An item that leaves no result or gives an overrun passes the back-end states FETCH
// (store read) and UPDATE (store write); one that completes its step also passes ACT
// (table interpolation) and SLOPE (slope multiply).
// After reset the back end clears min(SERIES_DEPTH, 1024) store entries, one a cycle
// (1024 by default); full stays high meanwhile.
// A two-word job queue and a two-word result queue let either side stall on its own.
module sigmoid_neuron_accumulate_top #(
	parameter int unsigned SERIES_DEPTH = sna_pkg::SERIES_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         push,
	input  sna_pkg::in_item_t            item,
	output logic                         full,
	// result channel
	input  logic                         pop,
	output sna_pkg::out_item_t           result,
	output logic                         empty,
	// configuration channel
	input  logic                         cfg_valid,
	input  logic [sna_pkg::COUNT_W-1:0]  cfg_data,
	output logic                         cfg_ready
);

	localparam int unsigned SLOT_W = (SERIES_DEPTH > 1) ? $clog2(SERIES_DEPTH) : 1;
	localparam int unsigned IN_W   = $bits(sna_pkg::in_item_t);
	localparam int unsigned JOB_W  = SLOT_W + IN_W;
	localparam int unsigned RES_W  = $bits(sna_pkg::out_item_t);

	// Fan-in register; always ready, the sender writes it only while no word is in flight
	logic [sna_pkg::COUNT_W-1:0] fan_in_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_in_q <= sna_pkg::COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			fan_in_q <= cfg_data;
		end
	end

	// Front end: accept, reduce step to store slot
	sna_pkg::back_stat_t stat;
	logic                jq_full;
	logic                jq_push;
	logic [SLOT_W-1:0]   jq_slot;
	sna_pkg::in_item_t   jq_item;

	sna_front #(
		.SERIES_DEPTH (SERIES_DEPTH),
		.SLOT_W       (SLOT_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.stat    (stat),
		.jq_full (jq_full),
		.jq_push (jq_push),
		.jq_slot (jq_slot),
		.jq_item (jq_item)
	);

	// Job queue between front and back
	logic [JOB_W-1:0] jq_rdata;
	logic             jq_empty;
	logic             jq_pop;

	sna_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (sna_pkg::JOB_Q_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.wdata  ({jq_slot, jq_item}),
		.full   (jq_full),
		.pop    (jq_pop),
		.rdata  (jq_rdata),
		.empty  (jq_empty)
	);

	// Back end: read-modify-write of the step store, activation
	logic               rq_full;
	logic               rq_push;
	sna_pkg::out_item_t rq_item;

	sna_back #(
		.SERIES_DEPTH (SERIES_DEPTH),
		.SLOT_W       (SLOT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fan_in   (fan_in_q),
		.job_vld  (!jq_empty),
		.job_slot (jq_rdata[JOB_W-1:IN_W]),
		.job_item (sna_pkg::in_item_t'(jq_rdata[IN_W-1:0])),
		.job_pop  (jq_pop),
		.res_full (rq_full),
		.res_push (rq_push),
		.res_item (rq_item),
		.stat     (stat)
	);

	// Result queue; the head word sits on the result port
	logic [RES_W-1:0] rq_rdata;

	sna_fifo #(
		.WIDTH (RES_W),
		.DEPTH (sna_pkg::RES_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_item),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign result = sna_pkg::out_item_t'(rq_rdata);

endmodule

// ===== hw/rtl/sna_fifo.sv =====
module sna_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/sna_front.sv =====
module sna_front #(
	parameter int unsigned SERIES_DEPTH = sna_pkg::SERIES_DEPTH_DEF,
	parameter int unsigned SLOT_W       = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sna_pkg::in_item_t    item,
	output logic                 full,
	input  sna_pkg::back_stat_t  stat,
	input  logic                 jq_full,
	output logic                 jq_push,
	output logic [SLOT_W-1:0]    jq_slot,
	output sna_pkg::in_item_t    jq_item
);

	logic              vld_s1;
	sna_pkg::in_item_t item_s1;
	logic              accept;
	logic              advance;

	assign full    = stat.clearing || (vld_s1 && jq_full);
	assign accept  = push && !full;
	assign advance = !vld_s1 || !jq_full;
	assign jq_push = vld_s1 && !jq_full;
	assign jq_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && accept) begin
			item_s1 <= item;
		end
	end

	if (SERIES_DEPTH < 1024) begin : g_reduce
		// step mod depth: quotient by reciprocal at entry, remainder in stage one
		localparam int unsigned RECIP = ((1 << 20) + SERIES_DEPTH - 1) / SERIES_DEPTH;
		logic [30:0]                q_prod;
		logic [sna_pkg::STEP_W-1:0] q_s1;
		logic [19:0]                qd;
		logic [sna_pkg::STEP_W-1:0] rem;

		assign q_prod  = {21'd0, item.step_index} * {10'd0, 21'(RECIP)};
		assign qd      = {10'd0, q_s1} * {10'd0, 10'(SERIES_DEPTH)};
		assign rem     = item_s1.step_index - qd[9:0];
		assign jq_slot = rem[SLOT_W-1:0];

		always_ff @(posedge clk) begin
			if (advance && accept) begin
				q_s1 <= q_prod[29:20];
			end
		end
	end else begin : g_direct
		assign jq_slot = SLOT_W'(item_s1.step_index);
	end

endmodule

// ===== hw/rtl/sna_back.sv =====
module sna_back #(
	parameter int unsigned SERIES_DEPTH = sna_pkg::SERIES_DEPTH_DEF,
	parameter int unsigned SLOT_W       = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sna_pkg::COUNT_W-1:0]   fan_in,
	input  logic                          job_vld,
	input  logic [SLOT_W-1:0]             job_slot,
	input  sna_pkg::in_item_t             job_item,
	output logic                          job_pop,
	input  logic                          res_full,
	output logic                          res_push,
	output sna_pkg::out_item_t            res_item,
	output sna_pkg::back_stat_t           stat
);

	localparam int unsigned CLR_N = (SERIES_DEPTH < 1024) ? SERIES_DEPTH : 1024;
	localparam logic [SLOT_W-1:0] CLR_LAST = SLOT_W'(CLR_N - 1);
	localparam int unsigned SUM_W = sna_pkg::SUM_W;
	localparam int unsigned ACT_W = sna_pkg::ACT_W;
	localparam int unsigned HI_W  = SUM_W - sna_pkg::STEP_SH;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_FETCH,
		ST_UPDATE,
		ST_ACT,
		ST_SLOPE
	} state_t;

	state_t                           state_q;
	logic [SLOT_W-1:0]                clr_q;
	logic [SLOT_W-1:0]                slot_q;
	logic [sna_pkg::STEP_W-1:0]       step_q;
	logic signed [sna_pkg::VALUE_W-1:0] value_q;
	logic signed [SUM_W-1:0]          sum_q;
	logic [ACT_W-1:0]                 act_q;
	sna_pkg::entry_t                  mem [SERIES_DEPTH];
	sna_pkg::entry_t                  rd_q;

	logic                             mem_we;
	logic [SLOT_W-1:0]                mem_waddr;
	sna_pkg::entry_t                  mem_wdata;
	logic                             mem_re;

	// Constant sigmoid samples
	logic [ACT_W-1:0] sig_tab [sna_pkg::TABLE_ENTRIES];
	for (genvar k = 0; k < sna_pkg::TABLE_ENTRIES; k++) begin : g_tab
		assign sig_tab[k] = sna_pkg::sig_sample(k);
	end

	// Update: saturating sum, saturating count, outcome
	logic signed [SUM_W:0]          sum_ext;
	logic signed [SUM_W-1:0]        sum_new;
	logic [sna_pkg::COUNT_W-1:0]    cnt_new;
	logic                           is_overrun;
	logic                           is_complete;

	always_comb begin
		sum_ext = {rd_q.sum[SUM_W-1], rd_q.sum}
			+ {{(SUM_W + 1 - sna_pkg::VALUE_W){value_q[sna_pkg::VALUE_W-1]}}, value_q};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_new = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end
		cnt_new     = (rd_q.count == sna_pkg::COUNT_MAX) ? rd_q.count : rd_q.count + 1'b1;
		is_overrun  = (rd_q.count >= fan_in);
		is_complete = ({1'b0, rd_q.count} + 9'd1) == {1'b0, fan_in};
	end

	// Sigmoid lookup with linear interpolation
	logic signed [SUM_W:0]            o;
	logic [HI_W-1:0]                  idx_hi;
	logic [sna_pkg::STEP_SH-1:0]      frac;
	logic [sna_pkg::TAB_IDX_W-1:0]    ti;
	logic [ACT_W-1:0]                 tab_a;
	logic [ACT_W-1:0]                 tab_b;
	logic [ACT_W+sna_pkg::STEP_SH-1:0] interp_prod;
	logic [ACT_W-1:0]                 act_n;

	always_comb begin
		o      = {sum_q[SUM_W-1], sum_q} + (SUM_W + 1)'(32768);
		idx_hi = o[SUM_W-1:sna_pkg::STEP_SH];
		frac   = o[sna_pkg::STEP_SH-1:0];
		ti     = idx_hi[sna_pkg::TAB_IDX_W-1:0];
		tab_a  = sig_tab[ti];
		if (ti == sna_pkg::TAB_IDX_W'(sna_pkg::TABLE_ENTRIES - 1)) begin
			tab_b = sna_pkg::ACT_MAX;
		end else begin
			tab_b = sig_tab[ti + 1'b1];
		end
		if (tab_b < tab_a) begin
			tab_b = tab_a;
		end
		interp_prod = (tab_b - tab_a) * {{(ACT_W){1'b0}}, frac};
		if (o[SUM_W]) begin
			act_n = sig_tab[0];
		end else if (idx_hi >= HI_W'(sna_pkg::TABLE_ENTRIES)) begin
			act_n = sna_pkg::ACT_MAX;
		end else begin
			act_n = tab_a + interp_prod[ACT_W+sna_pkg::STEP_SH-1:sna_pkg::STEP_SH];
		end
	end

	// Slope s*(1-s)
	logic [32:0] slope_prod;
	assign slope_prod = {17'd0, act_q} * {16'd0, 17'h1_0000 - {1'b0, act_q}};

	// Control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{count: cnt_new, sum: sum_new};
		mem_re    = 1'b0;
		job_pop   = 1'b0;
		res_push  = 1'b0;
		res_item  = '{out_step: step_q, activation: act_q,
			slope: slope_prod[30:16], overrun: 1'b0};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_FETCH: begin
				mem_re  = job_vld && !res_full;
				job_pop = job_vld && !res_full;
			end
			ST_UPDATE: begin
				mem_we = 1'b1;
				if (is_overrun) begin
					res_push = 1'b1;
					res_item = '{out_step: step_q, activation: '0, slope: '0, overrun: 1'b1};
				end
			end
			ST_SLOPE: begin
				res_push = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat.clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (job_vld && !res_full) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (!is_overrun && is_complete) begin
						state_q <= ST_ACT;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_ACT: begin
					state_q <= ST_SLOPE;
				end
				ST_SLOPE: begin
					state_q <= ST_FETCH;
				end
				default: begin
					state_q <= ST_FETCH;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			slot_q  <= job_slot;
			step_q  <= job_item.step_index;
			value_q <= job_item.incoming_value;
		end
		if (state_q == ST_UPDATE) begin
			sum_q <= sum_new;
		end
		if (state_q == ST_ACT) begin
			act_q <= act_n;
		end
	end

	// Step store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[job_slot];
		end
	end

endmodule

// ===== hw/rtl/sna_chk.sv =====
module sna_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         full,
	input logic                         pop,
	input sna_pkg::out_item_t           result,
	input logic                         empty
);

	logic [32:0] exp_prod;
	assign exp_prod = {17'd0, result.activation}
		* {16'd0, 17'h1_0000 - {1'b0, result.activation}};

	// An overrun word carries no activation and no slope
	a_overrun_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.overrun |-> result.activation == '0 && result.slope == '0)
		else $error("overrun word with nonzero activation or slope");

	// Slope matches the activation it travels with
	a_slope_match: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.overrun |-> result.slope == exp_prod[30:16])
		else $error("slope does not match activation");

	// Head word holds while not popped
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result word changed while waiting");

	// Nothing comes out in the first cycle after reset while the store clears
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty && full)
		else $error("block active right after reset");

endmodule

bind sigmoid_neuron_accumulate_top sna_chk u_sna_chk (.*);
